>>> src/odt_pkg.sv
// ----------------------------------------------------------------------------
// odt_pkg
// Shared constants, types and functions of the dirty tile transposer.
// ----------------------------------------------------------------------------
package odt_pkg;

   localparam int ODT_SCREENS        = 4;
   localparam int ODT_SCREEN_COLUMNS = 128;
   localparam int ODT_PAGES          = 8;

   localparam int ODT_DATA_W  = 64;
   localparam int ODT_PAGE_W  = 3;
   localparam int ODT_CCOL_W  = 6;
   localparam int ODT_CCOLS   = 2 ** ODT_CCOL_W;
   localparam int ODT_PAGE_IN = 2 ** ODT_PAGE_W;

   localparam logic [7:0] ODT_CMD_PAGE     = 8'hB0;
   localparam logic [7:0] ODT_CMD_COL_HIGH = 8'h10;

   typedef struct packed {
      logic       page_done;
      logic       page_changed;
      logic [3:0] start_tile;
      logic [4:0] tile_span;
      logic [7:0] cmd_page;
      logic [3:0] cmd_col_low;
      logic [7:0] cmd_col_high;
   } odt_summary_type;

   // Column j, bit b takes row b, pixel j (pixel 0 is the row's MSB).
   function automatic logic [ODT_DATA_W-1:0] odt_transpose(input logic [ODT_DATA_W-1:0] rows);
      logic [ODT_DATA_W-1:0] cols;
      cols = '0;
      for (int b = 0; b < 8; b++) begin
         for (int j = 0; j < 8; j++) begin
            cols[8*j+b] = rows[8*b+7-j];
         end
      end
      return cols;
   endfunction

endpackage

>>> src/odt_channels.sv
// ----------------------------------------------------------------------------
// odt_req_if / odt_rsp_if
// Valid/ready channels carrying canvas blocks in and tile results out.
// ----------------------------------------------------------------------------
interface odt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  page;
   logic [5:0]  canvas_column;
   logic [63:0] row_bits;
   logic        no_flip;

   modport source (output valid, page, canvas_column, row_bits, no_flip, input ready);
   modport sink   (input valid, page, canvas_column, row_bits, no_flip, output ready);
endinterface

interface odt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  screen;
   logic [3:0]  tile;
   logic [63:0] column_bytes;
   logic        tile_changed;
   logic        page_done;
   logic        page_changed;
   logic [3:0]  start_tile;
   logic [4:0]  tile_span;
   logic [7:0]  cmd_page;
   logic [3:0]  cmd_col_low;
   logic [7:0]  cmd_col_high;

   modport source (output valid, screen, tile, column_bytes, tile_changed, page_done,
                   page_changed, start_tile, tile_span, cmd_page, cmd_col_low,
                   cmd_col_high, input ready);
   modport sink   (input valid, screen, tile, column_bytes, tile_changed, page_done,
                   page_changed, start_tile, tile_span, cmd_page, cmd_col_low,
                   cmd_col_high, output ready);
endinterface

>>> src/oled_dirty_tile_transposer.sv
// ----------------------------------------------------------------------------
// oled_dirty_tile_transposer
// Transposes canvas blocks into page-format columns and tracks dirty tiles.
// ----------------------------------------------------------------------------
// Each request transaction carries one 8x8 canvas block with its page and
// canvas byte column; each response transaction returns the transposed
// column bytes, the physical screen and tile, whether the tile changed, and
// on the last tile of a page the page summary and address command bytes.
// The shadow entry of a request is read at the edge that accepts it; the
// block then passes through the compare stage into the output register.
// Throughput is one transaction per cycle once zeroing is done and while the
// receiver keeps up, set by the single read-compare-write of the shadow
// memory, with forwarding between back-to-back blocks to the same entry.
// After reset the shadow memory is zeroed, one entry per cycle, across all
// SCREENS * PAGES * SCREEN_COLUMNS / 8 entries (512 by default); req_bus.ready
// stays low meanwhile, while csr writes are taken at any time.
// When the receiver stalls, the output register holds its result, one more
// block is held in the compare stage, and ready then falls.
// csr_wr_en writes the screen flip control from csr_wr_data.
// ----------------------------------------------------------------------------
module oled_dirty_tile_transposer #(
   parameter int SCREENS        = odt_pkg::ODT_SCREENS,
   parameter int SCREEN_COLUMNS = odt_pkg::ODT_SCREEN_COLUMNS,
   parameter int PAGES          = odt_pkg::ODT_PAGES
) (
   input  logic         clock,
   input  logic         reset,
   odt_req_if.sink      req_bus,
   odt_rsp_if.source    rsp_bus,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);
   import odt_pkg::*;

   localparam int TILES  = SCREEN_COLUMNS / 8;
   localparam int DEPTH  = SCREENS * PAGES * TILES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TILE_W = (TILES > 1) ? $clog2(TILES) : 1;
   localparam int LOG_W  = (SCREENS > 1) ? $clog2(SCREENS) : 1;

   logic [LOG_W-1:0]      logical_tbl [ODT_CCOLS];
   logic [TILE_W-1:0]     tile_tbl    [ODT_CCOLS];
   logic [ODT_PAGE_W-1:0] page_tbl    [ODT_PAGE_IN];

   for (genvar gi = 0; gi < ODT_CCOLS; gi++) begin : g_col_tbl
      localparam int QUOT = (gi / TILES) % SCREENS;
      localparam int REMD = gi % TILES;
      assign logical_tbl[gi] = LOG_W'(QUOT);
      assign tile_tbl[gi]    = TILE_W'(REMD);
   end

   for (genvar gp = 0; gp < ODT_PAGE_IN; gp++) begin : g_page_tbl
      localparam int PMOD = gp % PAGES;
      assign page_tbl[gp] = ODT_PAGE_W'(PMOD);
   end

   logic                  flip_ff;
   logic                  accept;
   logic                  busy;
   logic [LOG_W-1:0]      logical;
   logic [LOG_W-1:0]      phys;
   logic [TILE_W-1:0]     tile_in;
   logic [ODT_PAGE_W-1:0] page_in;
   logic [ADDR_W-1:0]     addr_in;
   logic [ODT_DATA_W-1:0] cols_in;

   logic                  a_valid_ff;
   logic                  a_valid_in;
   logic                  a_adv;
   logic [ADDR_W-1:0]     a_addr_ff;
   logic [ODT_DATA_W-1:0] a_cols_ff;
   logic [LOG_W-1:0]      a_screen_ff;
   logic [TILE_W-1:0]     a_tile_ff;
   logic [ODT_PAGE_W-1:0] a_page_ff;
   logic                  a_fwd_ff;
   logic                  a_fwd_in;
   logic [ODT_DATA_W-1:0] a_fwd_data_ff;
   logic [ODT_DATA_W-1:0] rd_data;
   logic [ODT_DATA_W-1:0] shadow;
   logic                  a_dirty;
   odt_summary_type       summary;

   logic                  out_valid_ff;
   logic                  out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else if (csr_wr_en) begin
         flip_ff <= csr_wr_data;
      end
   end

   always_comb begin
      logical = logical_tbl[req_bus.canvas_column];
      tile_in = tile_tbl[req_bus.canvas_column];
      page_in = page_tbl[req_bus.page];
      phys    = (flip_ff && !req_bus.no_flip) ? (LOG_W'(SCREENS - 1) - logical) : logical;
      addr_in = ADDR_W'(phys) * ADDR_W'(PAGES * TILES) + ADDR_W'(page_in) * ADDR_W'(TILES)
              + ADDR_W'(tile_in);
      cols_in = odt_transpose(req_bus.row_bits);
   end

   assign a_adv         = a_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !busy && (!a_valid_ff || a_adv);
   assign accept        = req_bus.valid && req_bus.ready;
   assign a_valid_in    = accept || (a_valid_ff && !a_adv);
   assign a_fwd_in      = a_adv && (a_addr_ff == addr_in);
   assign out_valid_in  = a_adv || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_addr_ff     <= addr_in;
         a_cols_ff     <= cols_in;
         a_screen_ff   <= phys;
         a_tile_ff     <= tile_in;
         a_page_ff     <= page_in;
         a_fwd_ff      <= a_fwd_in;
         a_fwd_data_ff <= a_cols_ff;
      end
   end

   odt_shadow_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_shadow (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (addr_in),
      .rd_data (rd_data),
      .wr_en   (a_adv),
      .wr_addr (a_addr_ff),
      .wr_data (a_cols_ff),
      .busy    (busy)
   );

   assign shadow  = a_fwd_ff ? a_fwd_data_ff : rd_data;
   assign a_dirty = (shadow != a_cols_ff);

   odt_dirty_track #(
      .TILES  (TILES),
      .TILE_W (TILE_W)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .advance      (a_adv),
      .tile         (a_tile_ff),
      .tile_changed (a_dirty),
      .page         (a_page_ff),
      .summary      (summary)
   );

   always_ff @(posedge clock) begin
      if (a_adv) begin
         rsp_bus.screen       <= 2'(a_screen_ff);
         rsp_bus.tile         <= 4'(a_tile_ff);
         rsp_bus.column_bytes <= a_cols_ff;
         rsp_bus.tile_changed <= a_dirty;
         rsp_bus.page_done    <= summary.page_done;
         rsp_bus.page_changed <= summary.page_changed;
         rsp_bus.start_tile   <= summary.start_tile;
         rsp_bus.tile_span    <= summary.tile_span;
         rsp_bus.cmd_page     <= summary.cmd_page;
         rsp_bus.cmd_col_low  <= summary.cmd_col_low;
         rsp_bus.cmd_col_high <= summary.cmd_col_high;
      end
   end

   assign rsp_bus.valid = out_valid_ff;

endmodule

>>> src/odt_shadow_mem.sv
// ----------------------------------------------------------------------------
// odt_shadow_mem
// Shadow store of the last block sent per tile, with a zeroing pass after reset.
// ----------------------------------------------------------------------------
module odt_shadow_mem #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [odt_pkg::ODT_DATA_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [odt_pkg::ODT_DATA_W-1:0] wr_data,
   output logic                       busy
);
   import odt_pkg::*;

   logic [ODT_DATA_W-1:0] mem [DEPTH];
   logic [ODT_DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;
   logic [ADDR_W-1:0]     clr_addr_in;
   logic                  busy_ff;
   logic                  busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> src/odt_dirty_track.sv
// ----------------------------------------------------------------------------
// odt_dirty_track
// Tracks the first and last changed tile and forms the page summary and commands.
// ----------------------------------------------------------------------------
module odt_dirty_track #(
   parameter int TILES  = 16,
   parameter int TILE_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [TILE_W-1:0]         tile,
   input  logic                      tile_changed,
   input  logic [odt_pkg::ODT_PAGE_W-1:0] page,
   output odt_pkg::odt_summary_type  summary
);
   import odt_pkg::*;

   localparam int FD_W = $clog2(TILES + 1);

   logic [FD_W-1:0]   first_ff;
   logic [FD_W-1:0]   first_in;
   logic [TILE_W-1:0] last_ff;
   logic [TILE_W-1:0] last_in;
   logic [FD_W-1:0]   first_upd;
   logic [TILE_W-1:0] last_upd;
   logic              done;
   logic              pdirty;
   logic [TILE_W-1:0] ft;
   logic [TILE_W:0]   cnt;

   always_comb begin
      first_upd = first_ff;
      last_upd  = last_ff;
      if (tile_changed) begin
         if (first_ff >= FD_W'(TILES)) begin
            first_upd = FD_W'(tile);
         end
         last_upd = tile;
      end
      done   = (tile == TILE_W'(TILES - 1));
      pdirty = done && (first_upd < FD_W'(TILES));
      ft     = pdirty ? TILE_W'(first_upd) : '0;
      cnt    = '0;
      if (pdirty && (last_upd >= ft)) begin
         cnt = {1'b0, last_upd} - {1'b0, ft} + (TILE_W+1)'(1);
      end

      summary = '0;
      if (done) begin
         summary.page_done    = 1'b1;
         summary.page_changed = pdirty;
         summary.start_tile   = 4'(ft);
         summary.tile_span    = 5'(cnt);
         summary.cmd_page     = ODT_CMD_PAGE | 8'(page);
         summary.cmd_col_low  = {ft[0], 3'b000};
         summary.cmd_col_high = ODT_CMD_COL_HIGH | 8'(ft >> 1);
      end

      first_in = first_upd;
      last_in  = last_upd;
      if (done) begin
         first_in = FD_W'(TILES);
         last_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= FD_W'(TILES);
         last_ff  <= '0;
      end else if (advance) begin
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

endmodule

>>> test/odt_tile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odt_tile_checker
// Watches the request, response and csr ports of the dirty tile transposer.
// It keeps its own shadow copy, dirty tracking and flip setting, works out
// the tile result of every request transaction, and compares each response
// transaction, field by field, with the oldest result still outstanding.
// ----------------------------------------------------------------------------
module odt_tile_checker (
   input  logic clock,
   input  logic reset,
   odt_req_if   req_bus,
   odt_rsp_if   rsp_bus,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   mismatches,
   output int   pending,
   output int   checked,
   output int   dirty_tiles,
   output int   page_reports
);
   import odt_pkg::*;

   localparam int TILES       = ODT_SCREEN_COLUMNS / 8;
   localparam int STORE_DEPTH = ODT_SCREENS * ODT_PAGES * TILES;

   typedef struct packed {
      logic [1:0]      screen;
      logic [3:0]      tile;
      logic [63:0]     column_bytes;
      logic            tile_changed;
      odt_summary_type summary;
   } tile_result_type;

   logic [63:0]     shadow_copy [STORE_DEPTH];
   logic [4:0]      first_changed;
   logic [3:0]      last_changed;
   logic            flip_screens;
   tile_result_type expected_tiles [$];
   int              fault_count  = 0;
   int              result_count = 0;
   int              dirty_count  = 0;
   int              report_count = 0;

   function automatic logic [63:0] columns_of(input logic [63:0] rows);
      logic [63:0] cols;
      logic [7:0]  row;
      cols = '0;
      for (int b = 0; b < 8; b++) begin
         row = rows[8*b +: 8];
         for (int j = 0; j < 8; j++) begin
            cols[8*j + b] = row[7 - j];
         end
      end
      return cols;
   endfunction

   task automatic predict_tile(input logic [2:0] page, input logic [5:0] ccol,
                               input logic [63:0] rows, input logic no_flip,
                               output tile_result_type res);
      logic [1:0] logical;
      logic [1:0] phys;
      logic [3:0] tile;
      logic [8:0] slot;
      logic [3:0] ft;
      logic [7:0] start;
      logical = ccol[5:4];
      tile    = ccol[3:0];
      phys    = (flip_screens && !no_flip) ? 2'(ODT_SCREENS - 1) - logical : logical;
      slot    = {phys, page, tile};
      res              = '0;
      res.screen       = phys;
      res.tile         = tile;
      res.column_bytes = columns_of(rows);
      res.tile_changed = (shadow_copy[slot] != res.column_bytes);
      shadow_copy[slot] = res.column_bytes;
      if (res.tile_changed) begin
         if (first_changed >= TILES) begin
            first_changed = {1'b0, tile};
         end
         last_changed = tile;
      end
      if (tile == TILES - 1) begin
         res.summary.page_done = 1'b1;
         if (first_changed < TILES) begin
            ft = first_changed[3:0];
            res.summary.page_changed = 1'b1;
            res.summary.start_tile   = ft;
            res.summary.tile_span    = (last_changed >= ft) ?
                                       5'(last_changed - ft) + 5'd1 : 5'd0;
         end
         start = 8'(res.summary.start_tile) * 8'd8;
         res.summary.cmd_page     = ODT_CMD_PAGE | {5'b0, page};
         res.summary.cmd_col_low  = start[3:0];
         res.summary.cmd_col_high = ODT_CMD_COL_HIGH | {4'b0, start[7:4]};
         first_changed = 5'(TILES);
         last_changed  = '0;
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      tile_result_type want;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            shadow_copy[i] = '0;
         end
         first_changed = 5'(TILES);
         last_changed  = '0;
         flip_screens  = 1'b0;
         expected_tiles.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_tiles.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("%0t: response transaction for tile %0d with none outstanding",
                           $time, rsp_bus.tile);
               end
            end else begin
               want = expected_tiles.pop_front();
               compare_field("screen", 64'(want.screen), 64'(rsp_bus.screen));
               compare_field("tile", 64'(want.tile), 64'(rsp_bus.tile));
               compare_field("column_bytes", want.column_bytes, rsp_bus.column_bytes);
               compare_field("tile_changed", 64'(want.tile_changed),
                             64'(rsp_bus.tile_changed));
               compare_field("page_done", 64'(want.summary.page_done),
                             64'(rsp_bus.page_done));
               compare_field("page_changed", 64'(want.summary.page_changed),
                             64'(rsp_bus.page_changed));
               compare_field("start_tile", 64'(want.summary.start_tile),
                             64'(rsp_bus.start_tile));
               compare_field("tile_span", 64'(want.summary.tile_span),
                             64'(rsp_bus.tile_span));
               compare_field("cmd_page", 64'(want.summary.cmd_page), 64'(rsp_bus.cmd_page));
               compare_field("cmd_col_low", 64'(want.summary.cmd_col_low),
                             64'(rsp_bus.cmd_col_low));
               compare_field("cmd_col_high", 64'(want.summary.cmd_col_high),
                             64'(rsp_bus.cmd_col_high));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_tile(req_bus.page, req_bus.canvas_column, req_bus.row_bits,
                         req_bus.no_flip, want);
            if (want.tile_changed) begin
               dirty_count++;
            end
            if (want.summary.page_done) begin
               report_count++;
            end
            expected_tiles.push_back(want);
         end
         if (csr_wr_en) begin
            flip_screens = csr_wr_data;
         end
      end
      mismatches   <= fault_count;
      pending      <= expected_tiles.size();
      checked      <= result_count;
      dirty_tiles  <= dirty_count;
      page_reports <= report_count;
   end

endmodule

>>> test/oled_dirty_tile_transposer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_dirty_tile_transposer_test
// Drives canvas blocks into the dirty tile transposer and gives the verdict.
// A short directed sequence covers the field extremes, clean and dirty page
// ends, out-of-order dirty tiles and both flip settings; random phases then
// mix page scans, whole or partial, with stray blocks, with random gaps and stalls on both
// channels. All prediction and comparison is done by odt_tile_checker.
// ----------------------------------------------------------------------------
module oled_dirty_tile_transposer_test;
   import odt_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_BLOCKS = 950;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   odt_req_if req_bus ();
   odt_rsp_if rsp_bus ();

   int          mismatches;
   int          pending;
   int          checked;
   int          dirty_tiles;
   int          page_reports;
   int          blocks_sent  = 0;
   int          flip_writes  = 0;
   int          quiet_cycles = 0;
   bit          req_calm     = 1'b0;
   bit          rsp_calm     = 1'b0;
   logic [63:0] pattern_pool [4];

   oled_dirty_tile_transposer dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   odt_tile_checker tile_check (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .mismatches   (mismatches),
      .pending      (pending),
      .checked      (checked),
      .dirty_tiles  (dirty_tiles),
      .page_reports (page_reports)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, pending);
         $display("oled_dirty_tile_transposer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int stall;
      int served;
      served = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         served++;
         if (served % 40 == 0) begin
            rsp_calm = ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic logic [63:0] draw_rows();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return {$urandom, $urandom};
         4: return 64'd1 << $urandom_range(0, 63);
         default: return pattern_pool[2'($urandom_range(0, 3))];
      endcase
   endfunction

   task automatic send_block(input logic [2:0] page, input logic [5:0] ccol,
                             input logic [63:0] rows, input logic no_flip);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.page          <= page;
      req_bus.canvas_column <= ccol;
      req_bus.row_bits      <= rows;
      req_bus.no_flip       <= no_flip;
      do @(posedge clock); while (!req_bus.ready);
      blocks_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_flip(input logic value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      flip_writes++;
   endtask

   task automatic scan_page();
      logic [2:0] page;
      logic [1:0] screen;
      logic       no_flip;
      int         first;
      int         last;
      page    = 3'($urandom_range(0, 7));
      screen  = 2'($urandom_range(0, 3));
      no_flip = 1'($urandom_range(0, 1));
      first   = 0;
      last    = 15;
      if ($urandom_range(0, 4) == 0) begin
         first = $urandom_range(0, 15);
         last  = $urandom_range(first, 15);
      end
      for (int t = first; t <= last; t++) begin
         send_block(page, {screen, 4'(t)}, draw_rows(), no_flip);
      end
   endtask

   task automatic send_stray();
      logic [2:0] page;
      logic [5:0] ccol;
      logic       no_flip;
      page    = 3'($urandom_range(0, 7));
      ccol    = 6'($urandom_range(0, 63));
      no_flip = 1'($urandom_range(0, 1));
      send_block(page, ccol, draw_rows(), no_flip);
      if ($urandom_range(0, 3) == 0) begin
         send_block(page, ccol, draw_rows(), no_flip);
      end
   endtask

   initial begin
      int target;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= 1'b0;
      req_bus.valid         <= 1'b0;
      req_bus.page          <= '0;
      req_bus.canvas_column <= '0;
      req_bus.row_bits      <= '0;
      req_bus.no_flip       <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_flip(1'b0);
      req_calm = 1'b1;
      send_block(3'd0, 6'd15, 64'h0, 1'b0);
      send_block(3'd7, 6'd0, '1, 1'b0);
      send_block(3'd7, {2'd3, 4'd10}, 64'h0000_0000_0000_0080, 1'b0);
      send_block(3'd2, 6'd5, 64'h0100_0000_0000_0000, 1'b1);
      send_block(3'd7, 6'd31, 64'h0123_4567_89AB_CDEF, 1'b0);
      send_block(3'd7, 6'd31, 64'h0123_4567_89AB_CDEF, 1'b0);
      send_block(3'd4, 6'd13, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
      send_block(3'd4, 6'd2, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
      send_block(3'd4, 6'd15, 64'h0, 1'b0);
      send_block(3'd1, 6'd9, 64'hDEAD_BEEF_0000_0000, 1'b0);
      send_block(3'd1, 6'd9, 64'h0, 1'b0);
      send_block(3'd1, 6'd9, 64'h0, 1'b0);
      send_block(3'd1, 6'd47, '1, 1'b0);
      write_flip(1'b1);
      send_block(3'd3, 6'd0, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
      send_block(3'd3, 6'd0, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1);
      send_block(3'd3, 6'd48, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
      send_block(3'd3, 6'd63, 64'h0000_0000_0000_FFFF, 1'b1);
      send_block(3'd6, 6'd63, 64'h0, 1'b0);

      // Each phase runs with one flip setting and a fresh set of repeated patterns,
      // so that rewrites of unchanged tiles are common.
      target = blocks_sent + RANDOM_BLOCKS;
      for (int phase = 0; blocks_sent < target; phase++) begin
         write_flip(phase[0]);
         for (int i = 0; i < 4; i++) begin
            pattern_pool[i] = {$urandom, $urandom};
         end
         for (int n = 0; n < 12 && blocks_sent < target; n++) begin
            req_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
               scan_page();
            end else begin
               send_stray();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Checked %0d tile results from %0d canvas blocks: %0d dirty, %0d page reports.",
               checked, blocks_sent, dirty_tiles, page_reports);
      $display("The screen flip setting was written %0d times, covering both values.",
               flip_writes);
      if (mismatches == 0) begin
         $display("oled_dirty_tile_transposer verification clean");
      end else begin
         $display("oled_dirty_tile_transposer verification failed");
      end
      $finish;
   end

endmodule
